// ===== rtl/chs_pkg.sv =====
// Package for the chained hash set engine: command and status codes,
// plus the control and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chs_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_ABSENT   = 3'd4,
        ST_REMOVED  = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

    typedef struct packed {
        logic    take;        // latch key, start bucket reduction
        logic    sweep_start; // restart the clearing sweep
        logic    sweep_step;  // write one sweep row
        logic    ld_cur;      // load chain head into walk pointer
        logic    advance;     // step walk pointer along chain
        logic    rd_free;     // read link of free head
        logic    ins_write;   // link new entry at chain head
        logic    rem_unlink;  // bypass found entry
        logic    rem_free;    // push found entry on free list
        logic    note;        // capture result code
        status_t note_status;
        logic    emit;        // load output register
    } ctl_t;

    typedef struct packed {
        logic sweep_last;
        logic mod_done;
        logic cur_end;
        logic key_match;
        logic pool_empty;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/chained_hash_set_engine.sv =====
// Top level of the chained hash set engine: stream ports, controller and datapath.
// Depends on chs_pkg, chs_ctrl, chs_datapath.
//
//  Channel   Direction  Transaction carries
//  s_*       in         command, key
//  m_*       out        status, key_out, entry_count
//
// After reset the block sweeps max(BUCKETS, POOL_ENTRIES) rows of the bucket and
// link memories with s_tready low; clear runs the same sweep after it is accepted,
// then loads the output register.
// Other commands are accepted, then reduced to a bucket (a mask, or an iterative
// reduction when BUCKETS is not a power of two); the chain head is fetched, each
// chain node visited takes one memory read and one compare, and one more step
// follows when the walk runs off the chain end; an insert or a remove then writes
// the memories, and the output register is loaded. One item is in flight at a time;
// a result waiting on m_tready holds the block only when the next result is ready to go out.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_set_engine #(
    parameter int BUCKETS      = 1024,
    parameter int POOL_ENTRIES = 1024,
    parameter int KEY_BITS     = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [71:0] s_tdata,  // [1:0] command, [65:2] key, [71:66] zero
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [79:0] m_tdata   // [2:0] status, [66:3] key_out,
                                       // [77:67] entry_count, [79:78] zero
);
    import chs_pkg::*;

    ctl_t        ctl;
    stat_t       stat;
    logic [2:0]  out_status;
    logic [63:0] out_key;
    logic [10:0] out_count;

    chs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tdata[1:0]),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Keys wider than KEY_BITS drop their upper bits here
    chs_datapath #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .KEY_BITS     (KEY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .key_in     (s_tdata[2 +: KEY_BITS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_key    (out_key),
        .out_count  (out_count)
    );

    assign m_tdata = {2'b00, out_count, out_key, out_status};
endmodule
`default_nettype wire

// ===== rtl/chs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/chs_mod.sv =====
// Key-to-bucket reduction (key modulo BUCKETS): a mask for power-of-two
// counts, otherwise restoring reduction one 4-bit key digit per cycle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module chs_mod #(
    parameter int BUCKETS  = 1024,
    parameter int KEY_BITS = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [KEY_BITS-1:0]        key,
    output      logic                       done,
    output      logic [$clog2(BUCKETS)-1:0] rem
);
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int CNT_W = $clog2(KEY_BITS + 1);

    generate
        if ((1 << BKT_W) == BUCKETS)
        begin : g_mask
            logic [BKT_W-1:0] rem_reg;
            logic             done_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else if (start)
                begin
                    done_reg <= 1'b1;
                end
            end
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= BKT_W'(key);
                end
            end
            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else
        begin : g_iter
            localparam int DIGITS = (KEY_BITS + 3) / 4;
            localparam int PAD_W  = DIGITS * 4;
            localparam int TRY_W  = BKT_W + 4;
            logic [PAD_W-1:0] sh_reg;
            logic [BKT_W-1:0] rem_reg;
            logic [CNT_W-1:0] cnt_reg;
            logic [TRY_W-1:0] trial;
            logic [TRY_W-1:0] sub;
            assign trial = {rem_reg, sh_reg[PAD_W-1 -: 4]};
            // Take off the largest multiple of BUCKETS (up to 15) that fits
            always_comb
            begin
                sub = '0;
                for (int q = 1; q < 16; q++)
                begin
                    if (trial >= TRY_W'(q * BUCKETS))
                    begin
                        sub = TRY_W'(q * BUCKETS);
                    end
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= '0;
                end
                else if (start)
                begin
                    cnt_reg <= '0;
                end
                else if (cnt_reg != CNT_W'(DIGITS))
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    sh_reg  <= PAD_W'(key);
                    rem_reg <= '0;
                end
                else if (cnt_reg != CNT_W'(DIGITS))
                begin
                    sh_reg  <= sh_reg << 4;
                    rem_reg <= BKT_W'(trial - sub);
                end
            end
            assign done = (cnt_reg == CNT_W'(DIGITS)) && !start;
            assign rem  = rem_reg;
        end
    endgenerate
endmodule
`default_nettype wire

// ===== rtl/chs_datapath.sv =====
// Datapath: bucket/key/link memories, walk pointers, free list, count, result.
// Depends on chs_pkg, chs_ram, chs_mod.
`timescale 1ns / 1ps
`default_nettype none
module chs_datapath #(
    parameter int BUCKETS      = 1024,
    parameter int POOL_ENTRIES = 1024,
    parameter int KEY_BITS     = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire chs_pkg::ctl_t        ctl,
    output      chs_pkg::stat_t       stat,
    input  wire logic [KEY_BITS-1:0]  key_in,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [2:0]           out_status,
    output      logic [63:0]          out_key,
    output      logic [10:0]          out_count
);
    import chs_pkg::*;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int PIDX_W = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
    localparam int SW_D   = (BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES;
    localparam int SW_W   = $clog2(SW_D);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

    logic [KEY_BITS-1:0] key_reg;
    logic [LINK_W-1:0]   cur_reg, prev_reg, head_reg, free_reg, count_reg;
    logic [LINK_W-1:0]   steps_reg;
    logic [SW_W-1:0]     sw_reg;
    logic [2:0]          res_status_reg;
    logic [63:0]         res_key_reg;
    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [63:0]         out_key_reg;
    logic [10:0]         out_count_reg;

    logic [BKT_W-1:0]    bucket;
    logic                mod_done;
    logic [LINK_W-1:0]   heads_rd, links_rd;
    logic [KEY_BITS-1:0] keys_rd;

    logic                heads_we, links_we, keys_we;
    logic [BKT_W-1:0]    heads_wa;
    logic [LINK_W-1:0]   heads_wd, links_wd;
    logic [PIDX_W-1:0]   links_wa, pool_ra;
    logic [LINK_W+10:0]  count_ext;

    chs_mod #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.take),
        .key   (key_in),
        .done  (mod_done),
        .rem   (bucket)
    );

    // Write port selection for the two link-carrying memories
    always_comb
    begin
        heads_we = 1'b0;
        heads_wa = bucket;
        heads_wd = links_rd;
        links_we = 1'b0;
        links_wa = cur_reg[PIDX_W-1:0];
        links_wd = free_reg;
        keys_we  = ctl.ins_write;
        priority if (ctl.sweep_step)
        begin
            heads_we = (SW_W'(BUCKETS - 1) >= sw_reg);
            heads_wa = sw_reg[BKT_W-1:0];
            heads_wd = NIL;
            links_we = (SW_W'(POOL_ENTRIES - 1) >= sw_reg);
            links_wa = sw_reg[PIDX_W-1:0];
            links_wd = LINK_W'(sw_reg) + LINK_W'(1);
        end
        else if (ctl.ins_write)
        begin
            heads_we = 1'b1;
            heads_wd = free_reg;
            links_we = 1'b1;
            links_wa = free_reg[PIDX_W-1:0];
            links_wd = head_reg;
        end
        else if (ctl.rem_unlink)
        begin
            heads_we = (prev_reg == NIL);
            links_we = (prev_reg != NIL);
            links_wa = prev_reg[PIDX_W-1:0];
            links_wd = links_rd;
        end
        else if (ctl.rem_free)
        begin
            links_we = 1'b1;
        end
        pool_ra = ctl.rd_free ? free_reg[PIDX_W-1:0] : cur_reg[PIDX_W-1:0];
    end

    chs_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(heads_we), .waddr(heads_wa), .wdata(heads_wd),
        .raddr(bucket), .rdata(heads_rd)
    );
    chs_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_links (
        .clk(clk), .we(links_we), .waddr(links_wa), .wdata(links_wd),
        .raddr(pool_ra), .rdata(links_rd)
    );
    chs_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_ENTRIES)) u_keys (
        .clk(clk), .we(keys_we), .waddr(free_reg[PIDX_W-1:0]), .wdata(key_reg),
        .raddr(pool_ra), .rdata(keys_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg        <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.sweep_start)
            begin
                sw_reg <= '0;
            end
            else if (ctl.sweep_step)
            begin
                sw_reg <= sw_reg + SW_W'(1);
                if (sw_reg == SW_W'(SW_D - 1))
                begin
                    free_reg  <= '0;
                    count_reg <= '0;
                end
            end
            if (ctl.ins_write)
            begin
                free_reg  <= links_rd;
                count_reg <= count_reg + LINK_W'(1);
            end
            if (ctl.rem_free)
            begin
                free_reg <= cur_reg;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - LINK_W'(1);
                end
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = {11'b0, count_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            key_reg <= key_in;
        end
        if (ctl.ld_cur)
        begin
            cur_reg   <= heads_rd;
            head_reg  <= heads_rd;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end
        else if (ctl.advance)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= links_rd;
            steps_reg <= steps_reg + LINK_W'(1);
        end
        if (ctl.note)
        begin
            res_status_reg <= ctl.note_status;
            res_key_reg    <= (ctl.note_status == ST_FOUND) ? 64'(keys_rd) : 64'd0;
        end
        if (ctl.emit)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_count_reg  <= count_ext[10:0];
        end
    end

    always_comb
    begin
        stat.sweep_last = (sw_reg == SW_W'(SW_D - 1));
        stat.mod_done   = mod_done;
        stat.cur_end    = (cur_reg >= NIL) || (steps_reg == NIL);
        stat.key_match  = (keys_rd == key_reg);
        stat.pool_empty = (free_reg >= NIL);
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_count  = out_count_reg;
endmodule
`default_nettype wire

// ===== rtl/chs_ctrl.sv =====
// Controller state machine: sequences hashing, chain walk, updates and sweep.
// Depends on chs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output      logic           in_ready,
    input  wire logic [1:0]     in_cmd,
    input  wire chs_pkg::stat_t stat,
    output      chs_pkg::ctl_t  ctl
);
    import chs_pkg::*;

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_HASH = 11'b000_0000_0100,
        S_HEAD = 11'b000_0000_1000,
        S_LOAD = 11'b000_0001_0000,
        S_WALK = 11'b000_0010_0000,
        S_CMP  = 11'b000_0100_0000,
        S_INSR = 11'b000_1000_0000,
        S_INSW = 11'b001_0000_0000,
        S_REMF = 11'b010_0000_0000,
        S_RES  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic   report_reg, report_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        report_next = report_reg;
        ctl         = '0;
        ctl.note_status = ST_INSERTED;
        unique case (state_reg)
            S_CLR:
            begin
                ctl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.note        = 1'b1;
                    ctl.note_status = ST_CLEARED;
                    state_next      = report_reg ? S_RES : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.take    = 1'b1;
                    cmd_next    = cmd_t'(in_cmd);
                    report_next = 1'b1;
                    if (cmd_t'(in_cmd) == CMD_CLEAR)
                    begin
                        ctl.sweep_start = 1'b1;
                        state_next      = S_CLR;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctl.ld_cur = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (!stat.cur_end)
                begin
                    state_next = S_CMP;
                end
                else if (cmd_reg != CMD_INSERT)
                begin
                    ctl.note        = 1'b1;
                    ctl.note_status = ST_ABSENT;
                    state_next      = S_RES;
                end
                else if (stat.pool_empty)
                begin
                    ctl.note        = 1'b1;
                    ctl.note_status = ST_FULL;
                    state_next      = S_RES;
                end
                else
                begin
                    ctl.rd_free = 1'b1;
                    state_next  = S_INSR;
                end
            end
            S_CMP:
            begin
                if (!stat.key_match)
                begin
                    ctl.advance = 1'b1;
                    state_next  = S_WALK;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    ctl.note        = 1'b1;
                    ctl.note_status = ST_PRESENT;
                    state_next      = S_RES;
                end
                else if (cmd_reg == CMD_LOOKUP)
                begin
                    ctl.note        = 1'b1;
                    ctl.note_status = ST_FOUND;
                    state_next      = S_RES;
                end
                else
                begin
                    ctl.rem_unlink = 1'b1;
                    state_next     = S_REMF;
                end
            end
            S_INSR:
            begin
                // keep the free-head link on the read port for the write cycle
                ctl.rd_free = 1'b1;
                state_next  = S_INSW;
            end
            S_INSW:
            begin
                ctl.ins_write   = 1'b1;
                ctl.note        = 1'b1;
                ctl.note_status = ST_INSERTED;
                state_next      = S_RES;
            end
            S_REMF:
            begin
                ctl.rem_free    = 1'b1;
                ctl.note        = 1'b1;
                ctl.note_status = ST_REMOVED;
                state_next      = S_RES;
            end
            S_RES:
            begin
                if (!stat.out_busy)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cmd_reg    <= CMD_INSERT;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            report_reg <= report_next;
        end
    end
endmodule
`default_nettype wire
